// ----- hdl/fba_pkg.sv -----
// shared constants and types for the fixed block allocator
package fba_pkg;

  // pool geometry default
  localparam int unsigned POOL_BLOCKS_DEF = 1024;

  // block size register
  localparam int unsigned CFG_W            = 13;
  localparam logic [CFG_W-1:0] BLOCK_BYTES_RESET = 13'd8;
  localparam logic [CFG_W-1:0] MIN_BLOCK_BYTES   = 13'd8;
  localparam logic [CFG_W-1:0] MAX_BLOCK_BYTES   = 13'd4096;
  // log2 of the largest block size, extra address bits above the index
  localparam int unsigned SIZE_SHIFT       = 12;

  // request kinds
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  // response status codes
  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_EXHAUSTED   = 2'd1,
    ST_NULL_HANDLE = 2'd2,
    ST_LIST_FULL   = 2'd3
  } status_t;

endpackage

// ----- hdl/fba_ram.sv -----
// generic single-port-write, single-port-read ram with registered read data
module fba_ram #(
  parameter int unsigned WIDTH = 10,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/fba_addr_gen.sv -----
// byte address unit: clamps the block size and registers index times size
module fba_addr_gen #(
  parameter int unsigned IDX_W  = 10,
  parameter int unsigned ADDR_W = 22
) (
  input  logic                        clk,
  input  logic [fba_pkg::CFG_W-1:0]   block_bytes,
  input  logic [IDX_W-1:0]            index,
  output logic [ADDR_W-1:0]           byte_address
);

  localparam int unsigned PROD_W = IDX_W + fba_pkg::CFG_W;

  logic [fba_pkg::CFG_W-1:0] eff_size;
  logic [PROD_W-1:0]         prod;

  // clamp block size into the legal range
  always_comb begin
    if (block_bytes < fba_pkg::MIN_BLOCK_BYTES) begin
      eff_size = fba_pkg::MIN_BLOCK_BYTES;
    end else if (block_bytes > fba_pkg::MAX_BLOCK_BYTES) begin
      eff_size = fba_pkg::MAX_BLOCK_BYTES;
    end else begin
      eff_size = block_bytes;
    end
    prod = PROD_W'(index) * PROD_W'(eff_size);
  end

  // product register
  always_ff @(posedge clk) begin
    byte_address <= prod[ADDR_W-1:0];
  end

endmodule

// ----- hdl/fixed_block_allocator.sv -----
// top level of the fixed block allocator: request control, pointers and free queue
//
// One request at a time: start is taken while busy is low, and busy stays high until the
// response has been shown. A free and an allocate of a fresh block pass through S_MUL
// and S_RESP; an allocate from the free queue passes through S_FETCH first, which takes
// the registered read of the free queue memory. After done the block is ready again in
// the next cycle. The response is shown on status, granted_index and byte_address for
// exactly the one cycle in which done is high; the receiver cannot stall it. Freed
// blocks are handed out again oldest first; fresh blocks count up from zero.
// A block_index at or above POOL_BLOCKS is the null handle. block_bytes is clamped to
// 8..4096 and may only be written while busy is low.
module fixed_block_allocator #(
  parameter int unsigned POOL_BLOCKS = fba_pkg::POOL_BLOCKS_DEF,
  parameter int unsigned IDX_W  = $clog2(POOL_BLOCKS),
  parameter int unsigned BIN_W  = $clog2(POOL_BLOCKS + 1),
  parameter int unsigned ADDR_W = IDX_W + fba_pkg::SIZE_SHIFT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [fba_pkg::CFG_W-1:0] cfg_data,
  input  logic                      start,
  input  logic                      action,
  input  logic [BIN_W-1:0]          block_index,
  output logic                      busy,
  output logic                      done,
  output logic [1:0]                status,
  output logic [IDX_W-1:0]          granted_index,
  output logic [ADDR_W-1:0]         byte_address
);

  localparam int unsigned CNT_W = $clog2(POOL_BLOCKS + 1);
  localparam logic [CNT_W-1:0] POOL_CNT  = CNT_W'(POOL_BLOCKS);
  localparam logic [BIN_W-1:0] POOL_BIN  = BIN_W'(POOL_BLOCKS);
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(POOL_BLOCKS - 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_FETCH = 4'b0010,
    S_MUL   = 4'b0100,
    S_RESP  = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  logic [fba_pkg::CFG_W-1:0] block_bytes;
  logic [IDX_W-1:0]          queue_head;
  logic [IDX_W-1:0]          queue_tail;
  logic [CNT_W-1:0]          queue_count;
  logic [CNT_W-1:0]          next_fresh;
  logic [IDX_W-1:0]          granted;
  fba_pkg::status_t          status_q;

  logic             accept;
  logic             is_null;
  logic             is_full;
  logic             push;
  logic [IDX_W-1:0] ram_rdata;

  // request decode
  assign accept  = start && (state == S_IDLE);
  assign is_null = block_index >= POOL_BIN;
  assign is_full = queue_count == POOL_CNT;
  assign push    = accept && (action == fba_pkg::ACT_FREE) && !is_null && !is_full;

  // free queue storage, read always at the head slot
  fba_ram #(
    .WIDTH (IDX_W),
    .DEPTH (POOL_BLOCKS)
  ) u_queue_ram (
    .clk   (clk),
    .we    (push),
    .waddr (queue_tail),
    .wdata (block_index[IDX_W-1:0]),
    .raddr (queue_head),
    .rdata (ram_rdata)
  );

  // byte address multiplier
  fba_addr_gen #(
    .IDX_W  (IDX_W),
    .ADDR_W (ADDR_W)
  ) u_addr_gen (
    .clk          (clk),
    .block_bytes  (block_bytes),
    .index        (granted),
    .byte_address (byte_address)
  );

  // state sequencing
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if ((action == fba_pkg::ACT_ALLOC) && (queue_count != '0)) begin
            state_next = S_FETCH;
          end else begin
            state_next = S_MUL;
          end
        end
      end
      S_FETCH: state_next = S_MUL;
      S_MUL:   state_next = S_RESP;
      S_RESP:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // control registers: state, pointers, counts, block size
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      block_bytes <= fba_pkg::BLOCK_BYTES_RESET;
      queue_head  <= '0;
      queue_tail  <= '0;
      queue_count <= '0;
      next_fresh  <= '0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        block_bytes <= cfg_data;
      end
      if (accept) begin
        if (action == fba_pkg::ACT_ALLOC) begin
          if (queue_count != '0) begin
            queue_head  <= (queue_head == LAST_SLOT) ? '0 : queue_head + 1'b1;
            queue_count <= queue_count - 1'b1;
          end else if (next_fresh != POOL_CNT) begin
            next_fresh <= next_fresh + 1'b1;
          end
        end else if (push) begin
          queue_tail  <= (queue_tail == LAST_SLOT) ? '0 : queue_tail + 1'b1;
          queue_count <= queue_count + 1'b1;
        end
      end
    end
  end

  // response payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      granted  <= '0;
      status_q <= fba_pkg::ST_OK;
      if (action == fba_pkg::ACT_ALLOC) begin
        if (queue_count != '0) begin
          granted <= '0;
        end else if (next_fresh != POOL_CNT) begin
          granted <= next_fresh[IDX_W-1:0];
        end else begin
          status_q <= fba_pkg::ST_EXHAUSTED;
        end
      end else if (is_null) begin
        status_q <= fba_pkg::ST_NULL_HANDLE;
      end else if (is_full) begin
        status_q <= fba_pkg::ST_LIST_FULL;
      end
    end else if (state == S_FETCH) begin
      granted <= ram_rdata;
    end
  end

  // response ports
  assign busy          = state != S_IDLE;
  assign done          = state == S_RESP;
  assign status        = status_q;
  assign granted_index = granted;

endmodule

// ----- hdl/fba_checker.sv -----
// port level checks for the fixed block allocator, bound to the top level
module fba_checker #(
  parameter int unsigned POOL_BLOCKS = fba_pkg::POOL_BLOCKS_DEF,
  parameter int unsigned IDX_W  = $clog2(POOL_BLOCKS),
  parameter int unsigned ADDR_W = IDX_W + fba_pkg::SIZE_SHIFT
) (
  input logic                      clk,
  input logic                      rst,
  input logic                      start,
  input logic                      busy,
  input logic                      done,
  input logic [1:0]                status,
  input logic [IDX_W-1:0]          granted_index,
  input logic [ADDR_W-1:0]         byte_address
);

  // an accepted request holds off the next one
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request accepted but busy not raised");

  // a response is shown only while the request is still in flight
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("done without busy");

  // busy drops only right after the response strobe
  a_busy_end: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $fell(busy)) |-> $past(done))
    else $error("busy dropped without a response");

  // failed requests grant nothing
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (status != fba_pkg::ST_OK)) |-> (granted_index == '0 && byte_address == '0))
    else $error("error response carries a block");

  // block zero always sits at byte zero
  a_zero_addr: assert property (@(posedge clk) disable iff (rst)
    (done && granted_index == '0) |-> (byte_address == '0))
    else $error("nonzero address for block zero");

endmodule

bind fixed_block_allocator fba_checker #(
  .POOL_BLOCKS (POOL_BLOCKS),
  .IDX_W       (IDX_W),
  .ADDR_W      (ADDR_W)
) u_fba_checker (.*);
